/* sv/wffc_pkg.sv */
// ----------------------------------------------------------------------------
// wffc_pkg
// Types, codes and constants shared by the wheel force feedback controller.
// ----------------------------------------------------------------------------
package wffc_pkg;

    // opcodes and axis codes
    localparam logic [1:0] OP_AXIS    = 2'd0;
    localparam logic [1:0] OP_TARGET  = 2'd1;
    localparam logic [1:0] OP_TICK    = 2'd2;
    localparam logic [1:0] AXIS_WHEEL = 2'd0;

    // configuration register indexes
    localparam logic [2:0] CFG_DEADBAND    = 3'd0;
    localparam logic [2:0] CFG_BRAKE_ZONE  = 3'd1;
    localparam logic [2:0] CFG_BRAKE_GAIN  = 3'd2;
    localparam logic [2:0] CFG_TORQUE_LIM  = 3'd3;
    localparam logic [2:0] CFG_CENTER_MIN  = 3'd4;
    localparam logic [2:0] CFG_CENTER_MAX  = 3'd5;
    localparam logic [2:0] CFG_CENTER_SPAN = 3'd6;
    localparam logic [2:0] CFG_AUTO_CENTER = 3'd7;

    // configuration reset values
    localparam logic [15:0] RST_DEADBAND    = 16'd328;
    localparam logic [15:0] RST_BRAKE_ZONE  = 16'd3277;
    localparam logic [15:0] RST_BRAKE_GAIN  = 16'd16384;
    localparam logic [14:0] RST_TORQUE_LIM  = 15'd32767;
    localparam logic [14:0] RST_CENTER_MIN  = 15'd0;
    localparam logic [14:0] RST_CENTER_MAX  = 15'd16384;
    localparam logic [15:0] RST_CENTER_SPAN = 16'd16384;

    // q1.15 saturation levels
    localparam logic [15:0] Q15_POS_MAX = 16'h7fff;
    localparam logic [15:0] Q15_NEG_MAX = 16'h8000;

    // wheel range defaults
    localparam int WHEEL_MIN_DEF = 0;
    localparam int WHEEL_MAX_DEF = 65535;

    // command queue and divider sizing
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_AW    = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);
    localparam int DIV_NW     = 32;
    localparam int DIV_DW     = 16;
    localparam int DIV_QW     = 17;
    localparam int DIV_CW     = $clog2(DIV_QW + 1);

    typedef struct packed {
        logic [1:0]         op;
        logic [1:0]         axis_select;
        logic [15:0]        axis_value;
        logic signed [15:0] target_position;
        logic signed [15:0] target_torque;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] torque_level;
        logic               envelope_on;
        logic signed [15:0] wheel_position;
    } t_out_item;

    typedef struct packed {
        logic [15:0] deadband;
        logic [15:0] brake_zone;
        logic [15:0] brake_gain;
        logic [14:0] torque_limit;
        logic [14:0] centering_min_torque;
        logic [14:0] centering_max_torque;
        logic [15:0] centering_span;
        logic        auto_center_enable;
    } t_cfg;

    typedef enum logic [1:0] {
        K_AXIS,
        K_TARGET,
        K_TICK
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic               norm_neg;
        logic               norm_zero;
        logic [DIV_NW-1:0]  norm_num;
        logic [DIV_DW-1:0]  norm_den;
        logic signed [15:0] pos;
        logic [15:0]        mag;
    } t_cmd;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] num;
        logic [DIV_DW-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIV_QW-1:0] quot;
    } t_div_rsp;

    typedef enum logic [2:0] {
        S_IDLE,
        S_NORM,
        S_MUL,
        S_CHK,
        S_RDIV,
        S_TORQ,
        S_LEVEL
    } t_state;

endpackage

/* sv/wffc_front.sv */
// ----------------------------------------------------------------------------
// wffc_front
// Accepts input items, classifies them into commands and queues them.
// ----------------------------------------------------------------------------
module wffc_front
    import wffc_pkg::*;
#(
    parameter int WHEEL_MIN = WHEEL_MIN_DEF,
    parameter int WHEEL_MAX = WHEEL_MAX_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_in_item i_item,
    output logic     o_full,
    output logic     o_cmd_valid,
    output t_cmd     o_cmd,
    input  logic     i_cmd_take
);

    localparam logic [17:0] W_SUM = 18'(WHEEL_MAX + WHEEL_MIN);
    localparam bit W_DEGEN = (WHEEL_MAX <= WHEEL_MIN);
    localparam logic [DIV_DW-1:0] W_SPAN =
        W_DEGEN ? DIV_DW'(1) : DIV_DW'(WHEEL_MAX - WHEEL_MIN);

    t_cmd               r_q [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0] r_wp, r_rp;
    logic [CMDQ_CW-1:0] r_cnt;

    t_cmd        cmd;
    logic        keep;
    logic        enq;
    logic        deq;
    logic [17:0] s_norm;
    logic [16:0] norm_mag;

    always_comb begin
        s_norm   = 18'({1'b0, i_item.axis_value, 1'b0}) - W_SUM;
        norm_mag = s_norm[17] ? 17'(18'd0 - s_norm) : s_norm[16:0];

        cmd.kind      = K_TICK;
        cmd.norm_neg  = s_norm[17];
        cmd.norm_zero = W_DEGEN;
        cmd.norm_num  = {norm_mag, 15'd0};
        cmd.norm_den  = W_SPAN;
        cmd.pos       = i_item.target_position;
        cmd.mag       = i_item.target_torque[15] ? 16'(16'd0 - i_item.target_torque)
                                                 : i_item.target_torque;
        keep          = 1'b0;
        unique case (i_item.op)
            OP_AXIS: begin
                cmd.kind = K_AXIS;
                keep     = (i_item.axis_select == AXIS_WHEEL);
            end
            OP_TARGET: begin
                cmd.kind = K_TARGET;
                keep     = 1'b1;
            end
            OP_TICK: begin
                cmd.kind = K_TICK;
                keep     = 1'b1;
            end
            default: keep = 1'b0;
        endcase
    end

    assign o_full      = (r_cnt == CMDQ_CW'(CMDQ_DEPTH));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];
    assign enq         = i_push && !o_full && keep;
    assign deq         = i_cmd_take && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (enq) begin
                r_wp <= (r_wp == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (deq) begin
                r_rp <= (r_rp == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + CMDQ_CW'(enq) - CMDQ_CW'(deq);
        end
    end

    always_ff @(posedge i_clk) begin
        if (enq) begin
            r_q[r_wp] <= cmd;
        end
    end

endmodule

/* sv/wffc_div.sv */
// ----------------------------------------------------------------------------
// wffc_div
// Restoring divider, one quotient bit per cycle, saturating quotient.
// ----------------------------------------------------------------------------
module wffc_div
    import wffc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic              r_busy;
    logic [DIV_CW-1:0] r_cnt;
    logic              r_ovf;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_DW-1:0] r_den;
    logic [DIV_QW-1:0] r_sh;
    logic [DIV_QW-1:0] r_q;

    logic [DIV_DW:0]   trial;
    logic              ge;
    logic [DIV_NW-DIV_QW-1:0] num_hi;

    assign num_hi = i_req.num[DIV_NW-1:DIV_QW];
    assign trial  = {r_rem, r_sh[DIV_QW-1]};
    assign ge     = (trial >= {1'b0, r_den});

    assign o_rsp.done = r_busy && (r_cnt == '0);
    assign o_rsp.quot = r_ovf ? '1 : r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= DIV_CW'(DIV_QW);
        end else if (r_busy) begin
            if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
            end else begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= DIV_DW'(num_hi);
            r_ovf <= (DIV_DW'(num_hi) >= i_req.den);
            r_den <= i_req.den;
            r_sh  <= i_req.num[DIV_QW-1:0];
            r_q   <= '0;
        end else if (r_busy && (r_cnt != '0)) begin
            r_rem <= DIV_DW'(ge ? trial - {1'b0, r_den} : trial);
            r_sh  <= {r_sh[DIV_QW-2:0], 1'b0};
            r_q   <= {r_q[DIV_QW-2:0], ge};
        end
    end

endmodule

/* sv/wffc_back.sv */
// ----------------------------------------------------------------------------
// wffc_back
// Executes queued commands: position update, target store and torque ticks.
// ----------------------------------------------------------------------------
module wffc_back
    import wffc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_cmd_valid,
    input  t_cmd      i_cmd,
    output logic      o_cmd_take,
    output t_div_req  o_div_req,
    input  t_div_rsp  i_div_rsp,
    output logic      o_empty,
    output t_out_item o_out_item,
    input  logic      i_pop
);

    t_state             r_state, n_state;
    logic signed [15:0] r_cur, n_cur;
    logic signed [15:0] r_goal, n_goal;
    logic [15:0]        r_gtq, n_gtq;
    logic               r_latch, n_latch;
    logic [15:0]        r_err, n_err;
    logic               r_dir, n_dir;
    logic               r_ramp, n_ramp;
    logic               r_below, n_below;
    logic               r_cneg, n_cneg;
    logic [14:0]        r_cabs, n_cabs;
    logic               r_nneg, n_nneg;
    logic [31:0]        r_prod, n_prod;
    logic signed [18:0] r_torque, n_torque;
    logic               r_env, n_env;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out, n_out;

    logic signed [16:0] diff;
    logic [15:0]        mul_a, mul_b;
    logic [15:0]        cdiff;
    logic [16:0]        q;
    logic [15:0]        brk;
    logic signed [18:0] s_cmin, s_cmax, s_q, s_ramp, s_rcap, s_lim, s_t;
    logic [17:0]        m;
    logic [18:0]        m_up;
    logic [17:0]        lm;
    logic [15:0]        level;

    assign o_empty    = !r_out_valid;
    assign o_out_item = r_out;

    always_comb begin
        n_state     = r_state;
        n_cur       = r_cur;
        n_goal      = r_goal;
        n_gtq       = r_gtq;
        n_latch     = r_latch;
        n_err       = r_err;
        n_dir       = r_dir;
        n_ramp      = r_ramp;
        n_below     = r_below;
        n_cneg      = r_cneg;
        n_cabs      = r_cabs;
        n_nneg      = r_nneg;
        n_prod      = r_prod;
        n_torque    = r_torque;
        n_env       = r_env;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        o_cmd_take  = 1'b0;
        o_div_req   = '{start: 1'b0, num: i_cmd.norm_num, den: i_cmd.norm_den};

        diff  = 17'(r_goal) - 17'(r_cur);
        cdiff = {1'b0, i_cfg.centering_max_torque} - {1'b0, i_cfg.centering_min_torque};
        mul_a = r_ramp ? 16'(r_err - i_cfg.deadband) : r_gtq;
        mul_b = r_ramp ? {1'b0, r_cabs} : i_cfg.brake_gain;
        q     = i_div_rsp.quot;
        brk   = r_prod[30:15];

        s_cmin = $signed({4'b0, i_cfg.centering_min_torque});
        s_cmax = $signed({4'b0, i_cfg.centering_max_torque});
        s_q    = $signed({2'b0, q});
        if (i_cfg.centering_span <= i_cfg.deadband) begin
            s_ramp = s_cmax;
        end else begin
            s_ramp = r_cneg ? s_cmin - s_q : s_cmin + s_q;
        end
        s_rcap = (s_ramp > s_cmax) ? s_cmax : s_ramp;

        // level = t * 32767 / 32768 toward zero, saturated below
        s_lim = $signed({4'b0, i_cfg.torque_limit});
        s_t   = (r_torque > s_lim) ? s_lim : r_torque;
        m     = 18'(19'sd0 - s_t);
        m_up  = {1'b0, m} + 19'd32767;
        lm    = m - 18'(m_up[18:15]);
        if (s_t > 19'sd0) begin
            level = 16'(s_t - 19'sd1);
        end else if (s_t == 19'sd0) begin
            level = '0;
        end else if (lm > 18'd32768) begin
            level = Q15_NEG_MAX;
        end else begin
            level = 16'(18'd0 - lm);
        end

        if (i_pop && r_out_valid) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_take = 1'b1;
                    unique case (i_cmd.kind)
                        K_AXIS: begin
                            if (i_cmd.norm_zero) begin
                                n_cur = '0;
                            end else begin
                                o_div_req.start = 1'b1;
                                n_nneg          = i_cmd.norm_neg;
                                n_state         = S_NORM;
                            end
                        end
                        K_TARGET: begin
                            if (!(i_cmd.pos == r_goal && i_cmd.mag == r_gtq)) begin
                                n_goal  = i_cmd.pos;
                                n_gtq   = i_cmd.mag;
                                n_latch = 1'b0;
                            end
                        end
                        K_TICK: begin
                            n_dir   = (diff > 17'sd0);
                            n_err   = diff[16] ? 16'(17'sd0 - diff) : diff[15:0];
                            n_ramp  = r_latch || i_cfg.auto_center_enable;
                            n_cneg  = cdiff[15];
                            n_cabs  = cdiff[15] ? 15'(16'd0 - cdiff) : cdiff[14:0];
                            n_state = S_MUL;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_NORM: begin
                if (i_div_rsp.done) begin
                    if (r_nneg) begin
                        n_cur = (q >= 17'd32768) ? Q15_NEG_MAX : 16'(17'd0 - q);
                    end else begin
                        n_cur = (q >= 17'd32767) ? Q15_POS_MAX : q[15:0];
                    end
                    n_state = S_IDLE;
                end
            end
            S_MUL: begin
                n_below = (r_err < i_cfg.deadband);
                n_prod  = 32'(mul_a) * 32'(mul_b);
                n_state = S_CHK;
            end
            S_CHK: begin
                if (r_ramp && !r_below && (i_cfg.centering_span > i_cfg.deadband)) begin
                    o_div_req.start = 1'b1;
                    o_div_req.num   = r_prod;
                    o_div_req.den   = 16'(i_cfg.centering_span - i_cfg.deadband);
                    n_state         = S_RDIV;
                end else begin
                    n_state = S_TORQ;
                end
            end
            S_RDIV: begin
                if (i_div_rsp.done) begin
                    n_state = S_TORQ;
                end
            end
            S_TORQ: begin
                n_env    = 1'b0;
                n_torque = '0;
                if (r_below) begin
                    n_torque = '0;
                end else if (r_ramp) begin
                    n_torque = r_dir ? s_rcap : 19'sd0 - s_rcap;
                end else begin
                    n_env = 1'b1;
                    if (r_err < i_cfg.brake_zone) begin
                        n_latch  = 1'b1;
                        n_torque = r_dir ? 19'sd0 - $signed({3'b0, brk})
                                         : $signed({3'b0, brk});
                    end else begin
                        n_torque = r_dir ? $signed({3'b0, r_gtq})
                                         : 19'sd0 - $signed({3'b0, r_gtq});
                    end
                end
                n_state = S_LEVEL;
            end
            S_LEVEL: begin
                if (!r_out_valid || i_pop) begin
                    n_out_valid          = 1'b1;
                    n_out.torque_level   = level;
                    n_out.envelope_on    = r_env;
                    n_out.wheel_position = r_cur;
                    n_state              = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cur       <= '0;
            r_goal      <= '0;
            r_gtq       <= '0;
            r_latch     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cur       <= n_cur;
            r_goal      <= n_goal;
            r_gtq       <= n_gtq;
            r_latch     <= n_latch;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_err    <= n_err;
        r_dir    <= n_dir;
        r_ramp   <= n_ramp;
        r_below  <= n_below;
        r_cneg   <= n_cneg;
        r_cabs   <= n_cabs;
        r_nneg   <= n_nneg;
        r_prod   <= n_prod;
        r_torque <= n_torque;
        r_env    <= n_env;
        r_out    <= n_out;
    end

endmodule

/* sv/wheel_force_feedback_controller.sv */
// ----------------------------------------------------------------------------
// wheel_force_feedback_controller
// Q1.15 steering-wheel force controller with queue-style input and output.
//
// Input channel: push/full. Each transaction is an axis event, a target
// message or a control tick. Only control ticks produce a result.
// Output channel: empty/pop. The result (torque level, envelope flag, wheel
// position) sits on o_out_item while empty is low; a stalled result holds.
// Config channel: i_cfg_valid/o_cfg_ready with register index and data; write
// only while the block is idle.
// One transaction at a time, in the single back-end sequencer: target
//   message stored at once, control tick via multiply, check, ramp divide
//   if needed, torque, level; axis event via 17-step restoring divider.
// A two-entry command queue sits in front, so up to two commands can be
// pushed while the back end works or while a result waits to be popped.
// Reset (synchronous, active low) clears the queues, the positions, the goal
// torque and the brake latch and loads the register defaults.
// ----------------------------------------------------------------------------
module wheel_force_feedback_controller
    import wffc_pkg::*;
#(
    parameter int WHEEL_MIN = WHEEL_MIN_DEF,
    parameter int WHEEL_MAX = WHEEL_MAX_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  t_in_item    i_in_item,
    output logic        empty,
    input  logic        pop,
    output t_out_item   o_out_item,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_cfg     r_cfg;
    logic     cmd_valid;
    t_cmd     cmd;
    logic     cmd_take;
    t_div_req div_req;
    t_div_rsp div_rsp;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.deadband             <= RST_DEADBAND;
            r_cfg.brake_zone           <= RST_BRAKE_ZONE;
            r_cfg.brake_gain           <= RST_BRAKE_GAIN;
            r_cfg.torque_limit         <= RST_TORQUE_LIM;
            r_cfg.centering_min_torque <= RST_CENTER_MIN;
            r_cfg.centering_max_torque <= RST_CENTER_MAX;
            r_cfg.centering_span       <= RST_CENTER_SPAN;
            r_cfg.auto_center_enable   <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_DEADBAND:    r_cfg.deadband             <= i_cfg_data;
                CFG_BRAKE_ZONE:  r_cfg.brake_zone           <= i_cfg_data;
                CFG_BRAKE_GAIN:  r_cfg.brake_gain           <= i_cfg_data;
                CFG_TORQUE_LIM:  r_cfg.torque_limit         <= i_cfg_data[14:0];
                CFG_CENTER_MIN:  r_cfg.centering_min_torque <= i_cfg_data[14:0];
                CFG_CENTER_MAX:  r_cfg.centering_max_torque <= i_cfg_data[14:0];
                CFG_CENTER_SPAN: r_cfg.centering_span       <= i_cfg_data;
                CFG_AUTO_CENTER: r_cfg.auto_center_enable   <= i_cfg_data[0];
                default:         r_cfg.auto_center_enable   <= r_cfg.auto_center_enable;
            endcase
        end
    end

    wffc_front #(
        .WHEEL_MIN (WHEEL_MIN),
        .WHEEL_MAX (WHEEL_MAX)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (i_in_item),
        .o_full      (full),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_take  (cmd_take)
    );

    wffc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    wffc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_take  (cmd_take),
        .o_div_req   (div_req),
        .i_div_rsp   (div_rsp),
        .o_empty     (empty),
        .o_out_item  (o_out_item),
        .i_pop       (pop)
    );

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not cleared by reset");

    a_level_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_out_item.torque_level <= $signed({1'b0, r_cfg.torque_limit})))
        else $error("torque level above torque limit");

    a_env_no_center: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out_item.envelope_on) |-> !r_cfg.auto_center_enable)
        else $error("envelope set while auto centering");

    a_take_needs_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_take |-> cmd_valid)
        else $error("command taken from empty queue");

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the wheel force feedback controller.
// Axis events, target messages and control ticks go in through push/full.
// A scoreboard keeps its own copy of positions, goal torque, brake latch and
// registers, predicts the torque level of every tick and checks each popped
// result field by field. The run covers a directed opening and several
// register settings, extremes included, with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb;
    import wffc_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int W_MIN = WHEEL_MIN_DEF;
    localparam int W_MAX = WHEEL_MAX_DEF;

    class torque_scoreboard;
        t_cfg      cfg;
        shortint   wheel_pos;
        shortint   goal_pos;
        int        goal_mag;
        bit        latched;
        t_out_item pending_levels[$];
        int        errors;

        function void reset_state();
            cfg.deadband             = RST_DEADBAND;
            cfg.brake_zone           = RST_BRAKE_ZONE;
            cfg.brake_gain           = RST_BRAKE_GAIN;
            cfg.torque_limit         = RST_TORQUE_LIM;
            cfg.centering_min_torque = RST_CENTER_MIN;
            cfg.centering_max_torque = RST_CENTER_MAX;
            cfg.centering_span       = RST_CENTER_SPAN;
            cfg.auto_center_enable   = 1'b0;
            wheel_pos = 0;
            goal_pos  = 0;
            goal_mag  = 0;
            latched   = 1'b0;
            pending_levels.delete();
        endfunction

        function void set_reg(logic [2:0] idx, logic [15:0] data);
            case (idx)
                CFG_DEADBAND:    cfg.deadband             = data;
                CFG_BRAKE_ZONE:  cfg.brake_zone           = data;
                CFG_BRAKE_GAIN:  cfg.brake_gain           = data;
                CFG_TORQUE_LIM:  cfg.torque_limit         = data[14:0];
                CFG_CENTER_MIN:  cfg.centering_min_torque = data[14:0];
                CFG_CENTER_MAX:  cfg.centering_max_torque = data[14:0];
                CFG_CENTER_SPAN: cfg.centering_span       = data;
                CFG_AUTO_CENTER: cfg.auto_center_enable   = data[0];
                default: ;
            endcase
        endfunction

        function shortint wheel_from_raw(logic [15:0] raw);
            longint span;
            longint num;
            longint q;
            span = longint'(W_MAX) - longint'(W_MIN);
            if (span <= 0) return 0;
            num = (2 * longint'(raw) - W_MAX - W_MIN) * 32768;
            q = num / span;
            if (q > 32767) q = 32767;
            else if (q < -32768) q = -32768;
            return shortint'(q);
        endfunction

        function t_out_item predict_torque();
            t_out_item res;
            longint diff, err, dir, trq, ramp, cmin, cmax, db, span, lvl;
            diff = longint'(goal_pos) - longint'(wheel_pos);
            dir  = (diff > 0) ? 1 : -1;
            err  = (diff < 0) ? -diff : diff;
            db   = longint'(cfg.deadband);
            trq  = 0;
            res.envelope_on = 1'b0;
            if (latched || cfg.auto_center_enable) begin
                if (err >= db) begin
                    cmin = longint'(cfg.centering_min_torque);
                    cmax = longint'(cfg.centering_max_torque);
                    span = longint'(cfg.centering_span);
                    if (span <= db) ramp = cmax;
                    else ramp = cmin + (err - db) * (cmax - cmin) / (span - db);
                    if (ramp > cmax) ramp = cmax;
                    trq = ramp * dir;
                end
            end else if (err >= db) begin
                res.envelope_on = 1'b1;
                if (err < longint'(cfg.brake_zone)) begin
                    latched = 1'b1;
                    trq = -dir * ((longint'(goal_mag) * longint'(cfg.brake_gain)) >> 15);
                end else begin
                    trq = dir * longint'(goal_mag);
                end
            end
            if (trq > longint'(cfg.torque_limit)) trq = longint'(cfg.torque_limit);
            if (trq >= 0) lvl = (trq * 32767) / 32768;
            else lvl = -(((-trq) * 32767) / 32768);
            if (lvl < -32768) lvl = -32768;
            res.torque_level   = 16'(lvl);
            res.wheel_position = wheel_pos;
            return res;
        endfunction

        function void note_item(t_in_item it);
            int tq;
            int mag;
            case (it.op)
                OP_AXIS: begin
                    if (it.axis_select == AXIS_WHEEL) wheel_pos = wheel_from_raw(it.axis_value);
                end
                OP_TARGET: begin
                    tq  = it.target_torque;
                    mag = (tq < 0) ? -tq : tq;
                    if (!(shortint'(it.target_position) == goal_pos && mag == goal_mag)) begin
                        goal_pos = it.target_position;
                        goal_mag = mag;
                        latched  = 1'b0;
                    end
                end
                OP_TICK: pending_levels.push_back(predict_torque());
                default: ;
            endcase
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 200) $display("mismatch: %s", msg);
        endtask

        task check_result(t_out_item got);
            t_out_item want;
            if (pending_levels.size() == 0) begin
                report($sformatf("result with no tick pending, level %0d", got.torque_level));
                return;
            end
            want = pending_levels.pop_front();
            if (got.torque_level !== want.torque_level)
                report($sformatf("torque_level got %0d want %0d",
                                 got.torque_level, want.torque_level));
            if (got.envelope_on !== want.envelope_on)
                report($sformatf("envelope_on got %0b want %0b",
                                 got.envelope_on, want.envelope_on));
            if (got.wheel_position !== want.wheel_position)
                report($sformatf("wheel_position got %0d want %0d",
                                 got.wheel_position, want.wheel_position));
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        push;
    logic        full;
    t_in_item    i_in_item;
    logic        empty;
    logic        pop;
    t_out_item   o_out_item;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    torque_scoreboard sb;
    bit      calm;
    shortint gen_goal;
    shortint gen_torque;

    wheel_force_feedback_controller dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in_item   (i_in_item),
        .empty       (empty),
        .pop         (pop),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        pop = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            pop <= calm || ($urandom_range(99) >= 22);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) sb.check_result(o_out_item);
    end

    task automatic send_item(t_in_item it);
        while (!calm && $urandom_range(99) < 22) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push      <= 1'b1;
        i_in_item <= it;
        do @(posedge i_clk); while (full);
        sb.note_item(it);
        if (it.op == OP_TARGET) begin
            gen_goal   = it.target_position;
            gen_torque = it.target_torque;
        end
        @(negedge i_clk);
    endtask

    task automatic send_axis(logic [1:0] sel, logic [15:0] val);
        t_in_item it;
        it = '0;
        it.op          = OP_AXIS;
        it.axis_select = sel;
        it.axis_value  = val;
        send_item(it);
    endtask

    task automatic send_target(logic [15:0] pos, logic [15:0] tq);
        t_in_item it;
        it = '0;
        it.op              = OP_TARGET;
        it.target_position = pos;
        it.target_torque   = tq;
        send_item(it);
    endtask

    task automatic send_tick();
        t_in_item it;
        it = '0;
        it.op = OP_TICK;
        send_item(it);
    endtask

    task automatic drain_results();
        int waited;
        push <= 1'b0;
        waited = 0;
        while (sb.pending_levels.size() != 0 && waited < 20000) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (100) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic logic [15:0] rand_reg(logic [15:0] top);
        case ($urandom_range(9))
            0:       return 16'd0;
            1:       return top;
            2, 3, 4: return 16'($urandom_range(4000));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic load_settings(int phase);
        logic [15:0] db, bz, gain, lim, cmin, cmax, span, auto_c;
        case (phase)
            1: begin
                db = 16'd0; bz = 16'hffff; gain = 16'hffff; lim = 16'h7fff;
                cmin = 16'd0; cmax = 16'h7fff; span = 16'd0; auto_c = 16'd0;
            end
            2: begin
                db = 16'd0; bz = 16'd0; gain = 16'd0; lim = 16'd0;
                cmin = 16'h7fff; cmax = 16'd0; span = 16'hffff; auto_c = 16'd1;
            end
            3: begin
                db = 16'hffff; bz = 16'hffff; gain = 16'hffff; lim = 16'h7fff;
                cmin = 16'h7fff; cmax = 16'h7fff; span = 16'hffff; auto_c = 16'hffff;
            end
            default: begin
                db     = rand_reg(16'hffff);
                bz     = rand_reg(16'hffff);
                gain   = rand_reg(16'hffff);
                lim    = rand_reg(16'h7fff);
                cmin   = rand_reg(16'h7fff);
                cmax   = rand_reg(16'h7fff);
                span   = rand_reg(16'hffff);
                auto_c = 16'($urandom);
            end
        endcase
        write_reg(CFG_DEADBAND, db);
        write_reg(CFG_BRAKE_ZONE, bz);
        write_reg(CFG_BRAKE_GAIN, gain);
        write_reg(CFG_TORQUE_LIM, lim);
        write_reg(CFG_CENTER_MIN, cmin);
        write_reg(CFG_CENTER_MAX, cmax);
        write_reg(CFG_CENTER_SPAN, span);
        write_reg(CFG_AUTO_CENTER, auto_c);
    endtask

    function automatic t_in_item rand_item();
        t_in_item    it;
        logic [63:0] bits;
        int          pick;
        int          spread;
        int          raw;
        bits = {$urandom, $urandom};
        it   = bits[$bits(t_in_item)-1:0];
        pick = $urandom_range(99);
        if (pick < 30) begin
            it.op          = OP_AXIS;
            it.axis_select = AXIS_WHEEL;
            case ($urandom_range(9))
                0:       it.axis_value = 16'h0000;
                1:       it.axis_value = 16'hffff;
                2, 3:    ;
                default: begin
                    spread = $urandom_range(1) ? 600 : 8000;
                    raw = int'(gen_goal) + 32768 + int'($urandom_range(2 * spread)) - spread;
                    if (raw < 0) raw = 0;
                    if (raw > 65535) raw = 65535;
                    it.axis_value = raw[15:0];
                end
            endcase
        end else if (pick < 40) begin
            it.op = OP_TARGET;
            if ($urandom_range(2) == 0) begin
                it.target_position = gen_goal;
                it.target_torque   = $urandom_range(1) ? gen_torque : -gen_torque;
            end else if ($urandom_range(9) == 0) begin
                it.target_torque = 16'sh8000;
            end
        end else if (pick < 92) begin
            it.op = OP_TICK;
        end else if (pick < 96) begin
            it.op          = OP_AXIS;
            it.axis_select = 2'($urandom_range(3, 1));
        end else begin
            it.op = OP_UNUSED;
        end
        return it;
    endfunction

    task automatic run_random(int n);
        int       counted;
        t_in_item it;
        counted = 0;
        while (counted < n) begin
            it = rand_item();
            send_item(it);
            if (!(it.op == OP_UNUSED || (it.op == OP_AXIS && it.axis_select != AXIS_WHEEL)))
                counted++;
            if ($urandom_range(99) < 2) drain_results();
        end
    endtask

    task automatic run_directed();
        t_in_item it;
        send_tick();
        send_axis(AXIS_WHEEL, 16'h0000);
        send_target(16'h7fff, 16'h8000);
        send_tick();
        send_axis(AXIS_WHEEL, 16'hffff);
        send_tick();
        send_axis(AXIS_WHEEL, 16'd65000);
        send_tick();
        send_tick();
        // same goal and torque magnitude keeps the brake latch
        send_target(16'h7fff, 16'h8000);
        send_tick();
        send_target(16'h7fff, 16'h7fff);
        send_tick();
        send_axis(2'd3, 16'h0000);
        it = '1;
        it.op = OP_UNUSED;
        send_item(it);
        send_tick();
        send_axis(AXIS_WHEEL, 16'd32767);
        send_target(16'h8000, 16'h7fff);
        send_tick();
        send_axis(AXIS_WHEEL, 16'd32768);
        send_tick();
        // error exactly at the dead band edge
        send_target(16'h0000, 16'd1000);
        send_axis(AXIS_WHEEL, 16'd33096);
        send_tick();
    endtask

    initial begin
        i_rst_n     = 1'b0;
        push        = 1'b0;
        i_in_item   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        calm        = 1'b0;
        gen_goal    = 0;
        gen_torque  = 0;
        sb = new;
        sb.reset_state();
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        run_directed();
        for (int phase = 1; phase <= 8; phase++) begin
            drain_results();
            load_settings(phase);
            calm = (phase == 5);
            run_random(106);
        end
        drain_results();
        if (sb.pending_levels.size() != 0)
            sb.report($sformatf("%0d ticks never answered", sb.pending_levels.size()));
        if (sb.errors == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end

endmodule
